FILE: src/elr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ellipse outline rasterizer.
// Holds the controller-to-datapath command and status structs; no dependencies.
package elr_pkg;

    localparam int PITCH_W = 12;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd960;

    // Operand pair for the shared multiplier
    typedef logic [3:0] mul_sel_t;
    localparam mul_sel_t MUL_RA_RA    = 4'd0;
    localparam mul_sel_t MUL_RB_RB    = 4'd1;
    localparam mul_sel_t MUL_A2_RB    = 4'd2;
    localparam mul_sel_t MUL_TX_TX    = 4'd3;
    localparam mul_sel_t MUL_YM_YM    = 4'd4;
    localparam mul_sel_t MUL_B2_TXSQ  = 4'd5;
    localparam mul_sel_t MUL_A2_YMSQ  = 4'd6;
    localparam mul_sel_t MUL_A2_B2    = 4'd7;
    localparam mul_sel_t MUL_YA_PITCH = 4'd8;
    localparam mul_sel_t MUL_YB_PITCH = 4'd9;

    // Which of the four symmetric pixels is emitted
    typedef logic [1:0] emit_idx_t;
    localparam emit_idx_t EMIT_FIRST = 2'd0;
    localparam emit_idx_t EMIT_LAST  = 2'd3;

    typedef struct packed {
        logic      load_start;
        logic      step_move;
        logic      step_sum;
        logic      step_acc;
        logic      init1;
        logic      wr_a2;
        logic      wr_b2;
        logic      wr_rowa;
        logic      wr_rowb;
        logic      wr_txsq;
        logic      wr_ymsq;
        logic      set_r2;
        logic      dec_load_prod;
        logic      dec_add_prod4;
        logic      dec_sub_prod4;
        logic      emit_load;
        emit_idx_t emit_idx;
        mul_sel_t  mul_sel;
    } elr_cmd_t;

    typedef struct packed {
        logic r1_exit;
        logic in_r2;
        logic done;
        logic out_free;
    } elr_status_t;

endpackage

FILE: src/elr_datapath.sv
`timescale 1ns / 1ps
// Datapath of the ellipse outline rasterizer: geometry registers, shared multiplier,
// decision update and the output register. Depends on elr_pkg.
module elr_datapath
    import elr_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int ADDR_BITS  = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  elr_cmd_t              cmd,
    output elr_status_t           status,
    input  logic [COORD_BITS-1:0] corner_x1,
    input  logic [COORD_BITS-1:0] corner_y1,
    input  logic [COORD_BITS-1:0] corner_x2,
    input  logic [COORD_BITS-1:0] corner_y2,
    input  logic                  cfg_wr_en,
    input  logic [PITCH_W-1:0]    cfg_wr_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_BITS-1:0]  pixel_addr,
    output logic                  last,
    output logic                  done_res
);

    localparam int RAD_W = COORD_BITS - 1;
    localparam int SQ_W  = 2 * RAD_W;
    localparam int CUR_W = COORD_BITS + 1;
    localparam int DEC_W = 4 * COORD_BITS + 4;
    localparam int OPW   = 2 * COORD_BITS + 4;

    logic [PITCH_W-1:0]      pitch_reg;
    logic [RAD_W-1:0]        ra_reg, rb_reg;
    logic [COORD_BITS-1:0]   cx_reg, cy_reg;
    logic [SQ_W-1:0]         a2_reg, b2_reg;
    logic signed [CUR_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [DEC_W-1:0] x_term_reg, y_term_reg, dec_reg, sum_reg, prod_reg;
    logic signed [OPW-1:0]   txsq_reg, ymsq_reg;
    logic                    r2_reg, mvx_reg, mvy_reg;
    logic [COORD_BITS-1:0]   xa_reg, xb_reg, ya_reg, yb_reg;
    logic [ADDR_BITS-1:0]    rowa_reg, rowb_reg;
    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   px_reg, py_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic                    last_reg, done_reg;

    logic [COORD_BITS-1:0]   dx, dy;
    logic [COORD_BITS:0]     sx, sy;
    logic signed [DEC_W-1:0] a2_d, b2_d, prod4;
    logic signed [CUR_W:0]   tx, ym;
    logic signed [OPW-1:0]   op_a, op_b;
    logic signed [2*OPW-1:0] prod_full;
    logic                    dec_neg, dec_pos, mvx, mvy, out_free, done_now;
    logic [COORD_BITS-1:0]   sel_x, sel_y;
    logic [ADDR_BITS-1:0]    sel_row;

    // Corner arithmetic
    assign dx = (corner_x2 > corner_x1) ? corner_x2 - corner_x1 : corner_x1 - corner_x2;
    assign dy = (corner_y2 > corner_y1) ? corner_y2 - corner_y1 : corner_y1 - corner_y2;
    assign sx = {1'b0, corner_x1} + {1'b0, corner_x2};
    assign sy = {1'b0, corner_y1} + {1'b0, corner_y2};

    assign a2_d  = $signed(DEC_W'(a2_reg));
    assign b2_d  = $signed(DEC_W'(b2_reg));
    assign prod4 = prod_reg <<< 2;
    assign tx    = {cur_x_reg, 1'b1};
    assign ym    = (CUR_W + 1)'(cur_y_reg) - (CUR_W + 1)'(1);

    assign dec_neg = dec_reg[DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);
    assign mvx     = !r2_reg || !dec_pos;
    assign mvy     = r2_reg || !dec_neg;

    always_comb
    begin
        op_a = $signed(OPW'(ra_reg));
        op_b = $signed(OPW'(ra_reg));
        case (cmd.mul_sel)
            MUL_RA_RA:
            begin
                op_a = $signed(OPW'(ra_reg));
                op_b = $signed(OPW'(ra_reg));
            end
            MUL_RB_RB:
            begin
                op_a = $signed(OPW'(rb_reg));
                op_b = $signed(OPW'(rb_reg));
            end
            MUL_A2_RB:
            begin
                op_a = $signed(OPW'(a2_reg));
                op_b = $signed(OPW'(rb_reg));
            end
            MUL_TX_TX:
            begin
                op_a = OPW'(tx);
                op_b = OPW'(tx);
            end
            MUL_YM_YM:
            begin
                op_a = OPW'(ym);
                op_b = OPW'(ym);
            end
            MUL_B2_TXSQ:
            begin
                op_a = $signed(OPW'(b2_reg));
                op_b = txsq_reg;
            end
            MUL_A2_YMSQ:
            begin
                op_a = $signed(OPW'(a2_reg));
                op_b = ymsq_reg;
            end
            MUL_A2_B2:
            begin
                op_a = $signed(OPW'(a2_reg));
                op_b = $signed(OPW'(b2_reg));
            end
            MUL_YA_PITCH:
            begin
                op_a = $signed(OPW'(ya_reg));
                op_b = $signed(OPW'(pitch_reg));
            end
            MUL_YB_PITCH:
            begin
                op_a = $signed(OPW'(yb_reg));
                op_b = $signed(OPW'(pitch_reg));
            end
            default:
            begin
                op_a = $signed(OPW'(ra_reg));
                op_b = $signed(OPW'(ra_reg));
            end
        endcase
    end

    assign prod_full = op_a * op_b;

    // Pick the symmetric pixel for this transfer
    always_comb
    begin
        sel_x   = xa_reg;
        sel_y   = ya_reg;
        sel_row = rowa_reg;
        case (cmd.emit_idx)
            2'd0:
            begin
                sel_x   = xa_reg;
                sel_y   = ya_reg;
                sel_row = rowa_reg;
            end
            2'd1:
            begin
                sel_x   = xb_reg;
                sel_y   = ya_reg;
                sel_row = rowa_reg;
            end
            2'd2:
            begin
                sel_x   = xa_reg;
                sel_y   = yb_reg;
                sel_row = rowb_reg;
            end
            default:
            begin
                sel_x   = xb_reg;
                sel_y   = yb_reg;
                sel_row = rowb_reg;
            end
        endcase
    end

    assign done_now = r2_reg && cur_y_reg[CUR_W-1];
    assign out_free = !out_valid_reg || !out_stall;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg     <= PITCH_RESET;
            r2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                pitch_reg <= cfg_wr_data;
            if (cmd.load_start)
                r2_reg <= 1'b0;
            else if (cmd.set_r2)
                r2_reg <= 1'b1;
            if (cmd.emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[DEC_W-1:0];
        if (cmd.load_start)
        begin
            ra_reg     <= dx[COORD_BITS-1:1];
            rb_reg     <= dy[COORD_BITS-1:1];
            cx_reg     <= sx[COORD_BITS:1];
            cy_reg     <= sy[COORD_BITS:1];
            cur_x_reg  <= '0;
            cur_y_reg  <= $signed(CUR_W'(dy[COORD_BITS-1:1]));
            x_term_reg <= '0;
        end
        if (cmd.wr_a2)
            a2_reg <= prod_reg[SQ_W-1:0];
        if (cmd.wr_b2)
            b2_reg <= prod_reg[SQ_W-1:0];
        if (cmd.init1)
        begin
            y_term_reg <= prod_reg <<< 1;
            dec_reg    <= (b2_d <<< 2) - prod4 + a2_d;
        end
        if (cmd.step_move)
        begin
            // Latch the pixels of the current point, then advance it
            xa_reg  <= cx_reg + cur_x_reg[COORD_BITS-1:0];
            xb_reg  <= cx_reg - cur_x_reg[COORD_BITS-1:0];
            ya_reg  <= cy_reg + cur_y_reg[COORD_BITS-1:0];
            yb_reg  <= cy_reg - cur_y_reg[COORD_BITS-1:0];
            mvx_reg <= mvx;
            mvy_reg <= mvy;
            if (mvx)
            begin
                cur_x_reg  <= cur_x_reg + CUR_W'(1);
                x_term_reg <= x_term_reg + (b2_d <<< 1);
            end
            if (mvy)
            begin
                cur_y_reg  <= cur_y_reg - CUR_W'(1);
                y_term_reg <= y_term_reg - (a2_d <<< 1);
            end
        end
        if (cmd.step_sum)
            sum_reg <= (mvx_reg ? x_term_reg : '0) - (mvy_reg ? y_term_reg : '0)
                       + (r2_reg ? a2_d : b2_d);
        if (cmd.step_acc)
            dec_reg <= dec_reg + (sum_reg <<< 2);
        if (cmd.wr_rowa)
            rowa_reg <= prod_reg[ADDR_BITS-1:0];
        if (cmd.wr_rowb)
            rowb_reg <= prod_reg[ADDR_BITS-1:0];
        if (cmd.wr_txsq)
            txsq_reg <= prod_reg[OPW-1:0];
        if (cmd.wr_ymsq)
            ymsq_reg <= prod_reg[OPW-1:0];
        if (cmd.dec_load_prod)
            dec_reg <= prod_reg;
        if (cmd.dec_add_prod4)
            dec_reg <= dec_reg + prod4;
        if (cmd.dec_sub_prod4)
            dec_reg <= dec_reg - prod4;
        if (cmd.emit_load)
        begin
            px_reg   <= sel_x;
            py_reg   <= sel_y;
            addr_reg <= ADDR_BITS'(sel_x) + sel_row;
            last_reg <= (cmd.emit_idx == EMIT_LAST);
            done_reg <= done_now;
        end
    end

    assign status.r1_exit  = !((x_term_reg < y_term_reg) && !cur_y_reg[CUR_W-1]);
    assign status.in_r2    = r2_reg;
    assign status.done     = done_now;
    assign status.out_free = out_free;

    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign pixel_addr = addr_reg;
    assign last       = last_reg;
    assign done_res   = done_reg;

endmodule

FILE: src/elr_controller.sv
`timescale 1ns / 1ps
// Sequencer of the ellipse outline rasterizer: steps the datapath through setup,
// point update, region-two entry and the four pixel transfers. Depends on elr_pkg.
module elr_controller
    import elr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  elr_status_t status,
    output elr_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQA   = 4'd1;
    localparam logic [3:0] ST_SQB   = 4'd2;
    localparam logic [3:0] ST_YT    = 4'd3;
    localparam logic [3:0] ST_INIT  = 4'd4;
    localparam logic [3:0] ST_UPD2  = 4'd5;
    localparam logic [3:0] ST_UPD3  = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_E_TX  = 4'd8;
    localparam logic [3:0] ST_E_YM  = 4'd9;
    localparam logic [3:0] ST_E_BT  = 4'd10;
    localparam logic [3:0] ST_E_AY  = 4'd11;
    localparam logic [3:0] ST_E_AB  = 4'd12;
    localparam logic [3:0] ST_E_FIN = 4'd13;
    localparam logic [3:0] ST_EMIT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       active_reg, active_next;
    logic       from_step_reg, from_step_next;
    emit_idx_t  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            from_step_reg <= 1'b0;
            cnt_reg       <= EMIT_FIRST;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            from_step_reg <= from_step_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_RA_RA;
        cmd.emit_idx   = cnt_reg;
        state_next     = state_reg;
        active_next    = active_reg;
        from_step_next = from_step_reg;
        cnt_next       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = EMIT_FIRST;
                if (in_valid)
                begin
                    if (!func)
                    begin
                        cmd.load_start = 1'b1;
                        active_next    = 1'b1;
                        from_step_next = 1'b0;
                        state_next     = ST_SQA;
                    end
                    else if (active_reg)
                    begin
                        cmd.step_move  = 1'b1;
                        from_step_next = 1'b1;
                        state_next     = ST_UPD2;
                    end
                end
            end
            ST_SQA:
            begin
                cmd.mul_sel = MUL_RA_RA;
                state_next  = ST_SQB;
            end
            ST_SQB:
            begin
                cmd.wr_a2   = 1'b1;
                cmd.mul_sel = MUL_RB_RB;
                state_next  = ST_YT;
            end
            ST_YT:
            begin
                cmd.wr_b2   = 1'b1;
                cmd.mul_sel = MUL_A2_RB;
                state_next  = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init1  = 1'b1;
                state_next = ST_CHK;
            end
            ST_UPD2:
            begin
                cmd.step_sum = 1'b1;
                cmd.mul_sel  = MUL_YA_PITCH;
                state_next   = ST_UPD3;
            end
            ST_UPD3:
            begin
                cmd.step_acc = 1'b1;
                cmd.wr_rowa  = 1'b1;
                cmd.mul_sel  = MUL_YB_PITCH;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                cmd.wr_rowb = 1'b1;
                if (!status.in_r2 && status.r1_exit)
                    state_next = ST_E_TX;
                else if (from_step_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_E_TX:
            begin
                cmd.set_r2  = 1'b1;
                cmd.mul_sel = MUL_TX_TX;
                state_next  = ST_E_YM;
            end
            ST_E_YM:
            begin
                cmd.wr_txsq = 1'b1;
                cmd.mul_sel = MUL_YM_YM;
                state_next  = ST_E_BT;
            end
            ST_E_BT:
            begin
                cmd.wr_ymsq = 1'b1;
                cmd.mul_sel = MUL_B2_TXSQ;
                state_next  = ST_E_AY;
            end
            ST_E_AY:
            begin
                cmd.dec_load_prod = 1'b1;
                cmd.mul_sel       = MUL_A2_YMSQ;
                state_next        = ST_E_AB;
            end
            ST_E_AB:
            begin
                cmd.dec_add_prod4 = 1'b1;
                cmd.mul_sel       = MUL_A2_B2;
                state_next        = ST_E_FIN;
            end
            ST_E_FIN:
            begin
                cmd.dec_sub_prod4 = 1'b1;
                state_next        = from_step_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                // Hold the pixel until the output register frees up
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (cnt_reg == EMIT_LAST)
                    begin
                        state_next = ST_IDLE;
                        if (status.done)
                            active_next = 1'b0;
                    end
                    else
                        cnt_next = cnt_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ellipse_outline_rasterizer.sv
`timescale 1ns / 1ps
// Ellipse outline rasterizer, midpoint algorithm with two regions: top level.
// Ties elr_controller to elr_datapath; depends on elr_pkg.
//
// Send a start item (func 0) with two bounding-box corners, then one step item
// (func 1) per outline point; each step yields four pixel transfers in the order
// (cx+x,cy+y), (cx-x,cy+y), (cx+x,cy-y), (cx-x,cy-y), with last on the fourth and
// done_res on all four of the step that finishes the ellipse. Pixels are not
// clipped, duplicates are kept, and pixel_addr is pixel_x + pixel_y * row_pitch,
// wrapped to ADDR_BITS. The next item is taken only once the block is idle again;
// a start squares the radii and sets up the decision variable, and a step updates
// the point, forms the two row offsets, then hands out the pixels one per cycle
// unless out_stall holds them. Moving into region two happens once per ellipse, in
// the one shared multiplier. A step while no ellipse is active is accepted and
// ignored; a start always restarts. Write row_pitch only while the block is idle.
module ellipse_outline_rasterizer
    import elr_pkg::*;
#(
    parameter int COORD_BITS = 11,
    parameter int ADDR_BITS  = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [COORD_BITS-1:0] corner_x1,
    input  logic [COORD_BITS-1:0] corner_y1,
    input  logic [COORD_BITS-1:0] corner_x2,
    input  logic [COORD_BITS-1:0] corner_y2,
    input  logic                  cfg_wr_en,
    input  logic [PITCH_W-1:0]    cfg_wr_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [ADDR_BITS-1:0]  pixel_addr,
    output logic                  last,
    output logic                  done_res
);

    elr_cmd_t    cmd;
    elr_status_t status;

    // Sequencer: owns the handshake on the input side and the active flag
    elr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: geometry, multiplier, decision variable, output register
    elr_datapath #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .corner_x1   (corner_x1),
        .corner_y1   (corner_y1),
        .corner_x2   (corner_x2),
        .corner_y2   (corner_y2),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_addr  (pixel_addr),
        .last        (last),
        .done_res    (done_res)
    );

`ifndef SYNTHESIS
    // No input transfer while pixels are being handed out
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.emit_load)
        else $error("input transfer during pixel emit");

    // Only one writer of the decision variable per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.init1, cmd.step_acc, cmd.dec_load_prod,
                  cmd.dec_add_prod4, cmd.dec_sub_prod4}))
        else $error("conflicting decision updates");

    // The fourth pixel of a step returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && cmd.emit_idx == EMIT_LAST) |=> !in_stall)
        else $error("block not idle after last pixel");

    // Region two is entered only from region one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_r2 |-> !status.in_r2)
        else $error("region two entered twice");
`endif

endmodule
